### hw/rtl/pphit_pkg.sv
// Package with sizes, operation codes and controller/datapath structs for the hit test.
package pphit_pkg;

  localparam int MAX_POINTS = 64;
  localparam int AW         = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int CW         = 32;
  localparam int TW         = 31;
  localparam int DW         = CW + 1;
  localparam int OPW        = 68;
  localparam int DIG        = OPW / 2;
  localparam int PW         = 2 * OPW;
  localparam int SW         = PW + 1;
  localparam int LW         = 67;
  localparam int T2W        = 2 * TW;

  typedef logic [3:0] op_t;

  localparam op_t OP_TOL = 4'd0;
  localparam op_t OP_LXX = 4'd1;
  localparam op_t OP_LYY = 4'd2;
  localparam op_t OP_DX  = 4'd3;
  localparam op_t OP_DY  = 4'd4;
  localparam op_t OP_Q1A = 4'd5;
  localparam op_t OP_Q2A = 4'd6;
  localparam op_t OP_Q1B = 4'd7;
  localparam op_t OP_Q2B = 4'd8;
  localparam op_t OP_C1  = 4'd9;
  localparam op_t OP_C2  = 4'd10;
  localparam op_t OP_C3  = 4'd11;
  localparam op_t OP_C4  = 4'd12;

  typedef struct packed {
    logic          wr_en;
    logic          q_load;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          lat_a;
    logic          lat_b;
    logic          mul_start;
    op_t           op;
    logic          res_load;
  } cmd_t;

  typedef struct packed {
    logic             mul_done;
    logic             degen;
    logic             dot_le0;
    logic             far;
    logic             hit;
    logic [CNT_W-1:0] count;
  } status_t;

endpackage

### hw/rtl/pphit_if.sv
// Request and result channel interfaces of the hit test.
interface pphit_in_if;
  logic                        valid;
  logic                        ready;
  logic                        opcode;
  logic signed [pphit_pkg::CW-1:0] coord_x;
  logic signed [pphit_pkg::CW-1:0] coord_y;
  logic                        restart;
  logic [pphit_pkg::TW-1:0]    tolerance;

  modport source (output valid, opcode, coord_x, coord_y, restart, tolerance, input ready);
  modport sink   (input valid, opcode, coord_x, coord_y, restart, tolerance, output ready);
endinterface

interface pphit_out_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink   (input valid, hit, output ready);
endinterface

### hw/rtl/pphit_mul.sv
// Signed multiplier over four 34x34 partial products, one per cycle.
module pphit_mul (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic signed [pphit_pkg::OPW-1:0] a,
  input  logic signed [pphit_pkg::OPW-1:0] b,
  output logic                             done,
  output logic signed [pphit_pkg::SW-1:0]  prod
);

  logic                          busy_r;
  logic [2:0]                    cnt_r;
  logic                          done_r;
  logic [pphit_pkg::OPW-1:0]     am_r, bm_r;
  logic                          neg_r;
  logic [2*pphit_pkg::DIG-1:0]   pp_r;
  logic [1:0]                    sh_r;
  logic [pphit_pkg::PW-1:0]      acc_r;
  logic [pphit_pkg::OPW-1:0]     amag, bmag;
  logic [pphit_pkg::DIG-1:0]     ad, bd;
  logic [pphit_pkg::PW-1:0]      shifted;

  assign amag = a[pphit_pkg::OPW-1] ? pphit_pkg::OPW'(-a) : pphit_pkg::OPW'(a);
  assign bmag = b[pphit_pkg::OPW-1] ? pphit_pkg::OPW'(-b) : pphit_pkg::OPW'(b);
  assign ad = cnt_r[1] ? am_r[pphit_pkg::OPW-1:pphit_pkg::DIG] : am_r[pphit_pkg::DIG-1:0];
  assign bd = cnt_r[0] ? bm_r[pphit_pkg::OPW-1:pphit_pkg::DIG] : bm_r[pphit_pkg::DIG-1:0];

  always_comb begin
    unique case (sh_r)
      2'd0:    shifted = {{(pphit_pkg::PW-2*pphit_pkg::DIG){1'b0}}, pp_r};
      2'd1:    shifted = {{(pphit_pkg::PW-2*pphit_pkg::DIG){1'b0}}, pp_r} << pphit_pkg::DIG;
      2'd2:    shifted = {{(pphit_pkg::PW-2*pphit_pkg::DIG){1'b0}}, pp_r} << (2*pphit_pkg::DIG);
      default: shifted = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        acc_r  <= '0;
        am_r   <= amag;
        bm_r   <= bmag;
        neg_r  <= a[pphit_pkg::OPW-1] ^ b[pphit_pkg::OPW-1];
      end else if (busy_r) begin
        if (cnt_r != 3'd4) begin
          pp_r <= ad * bd;
          sh_r <= {1'b0, cnt_r[1]} + {1'b0, cnt_r[0]};
        end
        if (cnt_r != 3'd0) begin
          acc_r <= acc_r + shifted;
        end
        if (cnt_r == 3'd4) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 3'd1;
      end
    end
  end

  assign done = done_r;
  assign prod = neg_r ? -$signed({1'b0, acc_r}) : $signed({1'b0, acc_r});

endmodule

### hw/rtl/pphit_datapath.sv
// Datapath: vertex memory, segment registers, shared multiplier and result register.
module pphit_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  pphit_pkg::cmd_t                 cmd,
  output pphit_pkg::status_t              st,
  input  logic signed [pphit_pkg::CW-1:0] coord_x,
  input  logic signed [pphit_pkg::CW-1:0] coord_y,
  input  logic                            restart,
  input  logic [pphit_pkg::TW-1:0]        tolerance,
  output logic                            hit
);

  logic [2*pphit_pkg::CW-1:0]      mem [pphit_pkg::MAX_POINTS];
  logic [2*pphit_pkg::CW-1:0]      rd_r;
  logic [pphit_pkg::CNT_W-1:0]     count_r, base;
  logic signed [pphit_pkg::CW-1:0] px_r, py_r, ax_r, ay_r, bx_r, by_r;
  logic [pphit_pkg::T2W-1:0]       tol2_r;
  logic signed [pphit_pkg::SW-1:0] t0_r;
  logic signed [pphit_pkg::LW-1:0] len2_r, dot_r, cross_r;
  logic                            hit_r, out_hit_r;
  pphit_pkg::op_t                  op_r;
  logic signed [pphit_pkg::DW-1:0] abx, aby, dx, dy, ex, ey;
  logic signed [pphit_pkg::OPW-1:0] ma, mb;
  logic                            mdone;
  logic signed [pphit_pkg::SW-1:0] prod, sum, diff;

  function automatic logic signed [pphit_pkg::DW-1:0] DW_EXT(
    input logic signed [pphit_pkg::CW-1:0] v);
    DW_EXT = {v[pphit_pkg::CW-1], v};
  endfunction

  function automatic logic signed [pphit_pkg::OPW-1:0] op_ext(
    input logic signed [pphit_pkg::DW-1:0] v);
    op_ext = {{(pphit_pkg::OPW-pphit_pkg::DW){v[pphit_pkg::DW-1]}}, v};
  endfunction

  assign base = restart ? '0 : count_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_en && base < pphit_pkg::CNT_W'(pphit_pkg::MAX_POINTS)) begin
      mem[base[pphit_pkg::AW-1:0]] <= {coord_x, coord_y};
    end
    if (cmd.rd_en) begin
      rd_r <= mem[cmd.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.wr_en && base < pphit_pkg::CNT_W'(pphit_pkg::MAX_POINTS)) begin
      count_r <= base + 1'b1;
    end
  end

  assign abx = DW_EXT(bx_r) - DW_EXT(ax_r);
  assign aby = DW_EXT(by_r) - DW_EXT(ay_r);
  assign dx  = DW_EXT(px_r) - DW_EXT(ax_r);
  assign dy  = DW_EXT(py_r) - DW_EXT(ay_r);
  assign ex  = DW_EXT(px_r) - DW_EXT(bx_r);
  assign ey  = DW_EXT(py_r) - DW_EXT(by_r);

  always_comb begin
    unique case (cmd.op)
      pphit_pkg::OP_TOL: begin
        ma = {{(pphit_pkg::OPW-pphit_pkg::TW){1'b0}}, tolerance};
        mb = {{(pphit_pkg::OPW-pphit_pkg::TW){1'b0}}, tolerance};
      end
      pphit_pkg::OP_LXX: begin ma = op_ext(abx); mb = op_ext(abx); end
      pphit_pkg::OP_LYY: begin ma = op_ext(aby); mb = op_ext(aby); end
      pphit_pkg::OP_DX:  begin ma = op_ext(dx);  mb = op_ext(abx); end
      pphit_pkg::OP_DY:  begin ma = op_ext(dy);  mb = op_ext(aby); end
      pphit_pkg::OP_Q1A: begin ma = op_ext(dx);  mb = op_ext(dx);  end
      pphit_pkg::OP_Q2A: begin ma = op_ext(dy);  mb = op_ext(dy);  end
      pphit_pkg::OP_Q1B: begin ma = op_ext(ex);  mb = op_ext(ex);  end
      pphit_pkg::OP_Q2B: begin ma = op_ext(ey);  mb = op_ext(ey);  end
      pphit_pkg::OP_C1:  begin ma = op_ext(dx);  mb = op_ext(aby); end
      pphit_pkg::OP_C2:  begin ma = op_ext(dy);  mb = op_ext(abx); end
      pphit_pkg::OP_C3: begin
        ma = {{(pphit_pkg::OPW-pphit_pkg::LW){cross_r[pphit_pkg::LW-1]}}, cross_r};
        mb = {{(pphit_pkg::OPW-pphit_pkg::LW){cross_r[pphit_pkg::LW-1]}}, cross_r};
      end
      pphit_pkg::OP_C4: begin
        ma = {{(pphit_pkg::OPW-pphit_pkg::T2W){1'b0}}, tol2_r};
        mb = {{(pphit_pkg::OPW-pphit_pkg::LW){len2_r[pphit_pkg::LW-1]}}, len2_r};
      end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  pphit_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .a     (ma),
    .b     (mb),
    .done  (mdone),
    .prod  (prod)
  );

  assign sum  = t0_r + prod;
  assign diff = t0_r - prod;

  always_ff @(posedge clk) begin
    if (cmd.q_load) begin
      px_r  <= coord_x;
      py_r  <= coord_y;
      hit_r <= 1'b0;
    end
    if (cmd.lat_a) begin
      ax_r <= rd_r[2*pphit_pkg::CW-1:pphit_pkg::CW];
      ay_r <= rd_r[pphit_pkg::CW-1:0];
    end
    if (cmd.lat_b) begin
      bx_r <= rd_r[2*pphit_pkg::CW-1:pphit_pkg::CW];
      by_r <= rd_r[pphit_pkg::CW-1:0];
    end
    if (cmd.mul_start) begin
      op_r <= cmd.op;
    end
    if (mdone) begin
      unique case (op_r)
        pphit_pkg::OP_TOL: tol2_r <= prod[pphit_pkg::T2W-1:0];
        pphit_pkg::OP_LXX, pphit_pkg::OP_DX, pphit_pkg::OP_Q1A, pphit_pkg::OP_Q1B,
        pphit_pkg::OP_C1, pphit_pkg::OP_C3: t0_r <= prod;
        pphit_pkg::OP_LYY: len2_r <= sum[pphit_pkg::LW-1:0];
        pphit_pkg::OP_DY:  dot_r  <= sum[pphit_pkg::LW-1:0];
        pphit_pkg::OP_Q2A, pphit_pkg::OP_Q2B:
          hit_r <= sum <= $signed({{(pphit_pkg::SW-pphit_pkg::T2W){1'b0}}, tol2_r});
        pphit_pkg::OP_C2:  cross_r <= diff[pphit_pkg::LW-1:0];
        pphit_pkg::OP_C4:  hit_r <= t0_r <= prod;
        default: ;
      endcase
    end
    if (cmd.res_load) begin
      out_hit_r <= hit_r;
    end
  end

  assign st.mul_done = mdone;
  assign st.degen    = (ax_r == bx_r) && (ay_r == by_r);
  assign st.dot_le0  = dot_r[pphit_pkg::LW-1] || (dot_r == '0);
  assign st.far      = len2_r <= dot_r;
  assign st.hit      = hit_r;
  assign st.count    = count_r;
  assign hit         = out_hit_r;

endmodule

### hw/rtl/pphit_ctrl.sv
// Controller state machine: request handshake, segment walk and product sequencing.
module pphit_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_opcode,
  output logic                   out_valid,
  input  logic                   out_ready,
  output pphit_pkg::cmd_t        cmd,
  input  pphit_pkg::status_t     st
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL   = 4'd1;
  localparam logic [3:0] S_ISSUE = 4'd2;
  localparam logic [3:0] S_SEG   = 4'd3;
  localparam logic [3:0] S_RDB   = 4'd4;
  localparam logic [3:0] S_LATB  = 4'd5;
  localparam logic [3:0] S_CHK   = 4'd6;
  localparam logic [3:0] S_DEC   = 4'd7;
  localparam logic [3:0] S_EVAL  = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0]                state_r, state_nxt;
  logic [pphit_pkg::AW-1:0]  idx_r, idx_nxt;
  pphit_pkg::op_t            op_r, op_nxt;
  logic                      out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    op_nxt        = op_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.op        = op_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (!in_opcode) begin
            cmd.wr_en = 1'b1;
          end else begin
            cmd.q_load    = 1'b1;
            cmd.mul_start = 1'b1;
            cmd.op        = pphit_pkg::OP_TOL;
            op_nxt        = pphit_pkg::OP_TOL;
            state_nxt     = S_MUL;
          end
        end
      end
      S_MUL: begin
        if (st.mul_done) begin
          state_nxt = S_ISSUE;
          unique case (op_r)
            pphit_pkg::OP_TOL: begin idx_nxt = '0; state_nxt = S_SEG; end
            pphit_pkg::OP_LXX: op_nxt = pphit_pkg::OP_LYY;
            pphit_pkg::OP_LYY: op_nxt = pphit_pkg::OP_DX;
            pphit_pkg::OP_DX:  op_nxt = pphit_pkg::OP_DY;
            pphit_pkg::OP_DY:  state_nxt = S_DEC;
            pphit_pkg::OP_Q1A: op_nxt = pphit_pkg::OP_Q2A;
            pphit_pkg::OP_Q1B: op_nxt = pphit_pkg::OP_Q2B;
            pphit_pkg::OP_C1:  op_nxt = pphit_pkg::OP_C2;
            pphit_pkg::OP_C2:  op_nxt = pphit_pkg::OP_C3;
            pphit_pkg::OP_C3:  op_nxt = pphit_pkg::OP_C4;
            default:           state_nxt = S_EVAL;
          endcase
        end
      end
      S_ISSUE: begin
        cmd.mul_start = 1'b1;
        state_nxt     = S_MUL;
      end
      S_SEG: begin
        if (pphit_pkg::CNT_W'(idx_r) + 1'b1 < st.count) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = idx_r;
          state_nxt   = S_RDB;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_RDB: begin
        cmd.lat_a   = 1'b1;
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = idx_r + 1'b1;
        state_nxt   = S_LATB;
      end
      S_LATB: begin
        cmd.lat_b = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (st.degen) begin
          state_nxt = S_EVAL;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.op        = pphit_pkg::OP_LXX;
          op_nxt        = pphit_pkg::OP_LXX;
          state_nxt     = S_MUL;
        end
      end
      S_DEC: begin
        priority if (st.dot_le0) op_nxt = pphit_pkg::OP_Q1A;
        else if (st.far)         op_nxt = pphit_pkg::OP_Q1B;
        else                     op_nxt = pphit_pkg::OP_C1;
        state_nxt = S_ISSUE;
      end
      S_EVAL: begin
        if (st.hit) begin
          state_nxt = S_DONE;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_SEG;
        end
      end
      S_DONE: begin
        if (!out_valid_r) begin
          cmd.res_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      op_r        <= pphit_pkg::OP_TOL;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      op_r        <= op_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### hw/rtl/polyline_point_hit_test_top.sv
// Top level of the polyline point hit test.
//   channel   dir  payload                                    handshake
//   in_req    in   opcode, coord_x, coord_y, restart, tolerance valid/ready
//   out_res   out  hit                                         valid/ready
// An append request keeps the block ready and produces no result.
// A query first squares the tolerance, then walks the segments of the n stored vertices and
// stops at the first hit; a segment reads its ends, then takes eight products on the single
// shared multiplier, a decision and an evaluation, or only six products when the nearest
// point is an end of the segment, and a degenerate segment skips the products.
// Reset is synchronous and active low and empties the polyline; the memory is not cleared.
// A waiting result does not block appends; a finished query waits while an earlier result
// is still pending.
module polyline_point_hit_test_top (
  input  logic               clk,
  input  logic               rst_n,
  pphit_in_if.sink           in_req,
  pphit_out_if.source        out_res
);

  pphit_pkg::cmd_t    cmd;
  pphit_pkg::status_t st;

  pphit_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .in_opcode (in_req.opcode),
    .out_valid (out_res.valid),
    .out_ready (out_res.ready),
    .cmd       (cmd),
    .st        (st)
  );

  pphit_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .st        (st),
    .coord_x   (in_req.coord_x),
    .coord_y   (in_req.coord_y),
    .restart   (in_req.restart),
    .tolerance (in_req.tolerance),
    .hit       (out_res.hit)
  );

endmodule

### hw/rtl/pphit_checker.sv
// Port checker for the hit test and its bind to the top level.
module pphit_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_opcode,
  input logic out_valid,
  input logic out_ready,
  input logic out_hit
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result request dropped while stalled");

  a_hit_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_hit))
    else $error("result payload changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result request present after reset");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_opcode |=> !in_ready)
    else $error("request taken while a query is in progress");

  a_append_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_opcode |=> in_ready)
    else $error("append request left the block not ready");

endmodule

bind polyline_point_hit_test_top pphit_checker u_pphit_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_req.valid),
  .in_ready  (in_req.ready),
  .in_opcode (in_req.opcode),
  .out_valid (out_res.valid),
  .out_ready (out_res.ready),
  .out_hit   (out_res.hit)
);
